FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the complex pair arithmetic unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence on the same clock edge.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/cpa_pkg.sv
// Package for the complex pair arithmetic unit: widths, pipeline depths and stage types.
// No dependencies.
`default_nettype none
package cpa_pkg;
    localparam int OpW      = 16;
    localparam int SumW     = 17;
    localparam int PrW      = 32;
    localparam int PiW      = 33;
    localparam int NumW     = 33;   // numerator of the division
    localparam int DenW     = 32;   // |b|^2 is at most 2^31
    localparam int DividW   = 41;   // numerator times 256
    localparam int QMagW    = 41;   // quotient magnitude bits
    localparam int DivSteps = 41;   // one quotient bit per stage
    localparam int InW      = 64;
    localparam int OutW     = 168;

    // Values that the divider carries alongside the division.
    typedef struct packed {
        logic signed [SumW-1:0] sum_re;
        logic signed [SumW-1:0] sum_im;
        logic signed [SumW-1:0] diff_re;
        logic signed [SumW-1:0] diff_im;
        logic signed [PrW-1:0]  prod_re;
        logic signed [PiW-1:0]  prod_im;
        logic                   neg_re;
        logic                   neg_im;
        logic                   zero;
    } side_t;
endpackage
`default_nettype wire

FILE: rtl/core/cpa_front.sv
// Front stages: sums, differences, products, division numerators and denominator.
// Depends on cpa_pkg.
`default_nettype none
module cpa_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [cpa_pkg::OpW-1:0] a_re,
    input  wire logic signed [cpa_pkg::OpW-1:0] a_im,
    input  wire logic signed [cpa_pkg::OpW-1:0] b_re,
    input  wire logic signed [cpa_pkg::OpW-1:0] b_im,
    output logic                               out_valid,
    output cpa_pkg::side_t                     side,
    output logic [cpa_pkg::DividW-1:0]         mag_re,
    output logic [cpa_pkg::DividW-1:0]         mag_im,
    output logic [cpa_pkg::DenW-1:0]           den
);
    import cpa_pkg::*;

    // Stage 1: four-plus-two products, the sums and the differences.
    logic                    v1_reg;
    logic signed [31:0]      rr_reg, ii_reg, ri_reg, ir_reg, bb_reg, cc_reg;
    logic signed [SumW-1:0]  sr_reg, si_reg, dr_reg, di_reg;
    // Stage 2: combined numerators and denominator.
    logic                    v2_reg;
    logic signed [NumW-1:0]  nr_reg, ni_reg;
    logic [DenW-1:0]         den_reg;
    side_t                   s2_reg;
    logic signed [NumW-1:0]  nr_next, ni_next;
    logic [32:0]             den_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        nr_next  = NumW'(rr_reg) + NumW'(ii_reg);
        ni_next  = NumW'(ir_reg) - NumW'(ri_reg);
        den_next = 33'($unsigned(bb_reg)) + 33'($unsigned(cc_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg <= a_re * b_re;
            ii_reg <= a_im * b_im;
            ri_reg <= a_re * b_im;
            ir_reg <= a_im * b_re;
            bb_reg <= b_re * b_re;
            cc_reg <= b_im * b_im;
            sr_reg <= SumW'(a_re) + SumW'(b_re);
            si_reg <= SumW'(a_im) + SumW'(b_im);
            dr_reg <= SumW'(a_re) - SumW'(b_re);
            di_reg <= SumW'(a_im) - SumW'(b_im);
            nr_reg <= nr_next;
            ni_reg <= ni_next;
            den_reg <= den_next[DenW-1:0];
            s2_reg.sum_re  <= sr_reg;
            s2_reg.sum_im  <= si_reg;
            s2_reg.diff_re <= dr_reg;
            s2_reg.diff_im <= di_reg;
            s2_reg.prod_re <= rr_reg - ii_reg;
            s2_reg.prod_im <= PiW'(ri_reg) + PiW'(ir_reg);
            s2_reg.neg_re  <= 1'b0;
            s2_reg.neg_im  <= 1'b0;
            s2_reg.zero    <= (den_next == '0);
        end
    end

    // Stage 3 output: sign-magnitude split of the scaled numerators.
    logic                   v3_reg;
    side_t                  s3_reg;
    side_t                  s3_next;
    logic [DividW-1:0]      mr_reg, mi_reg;
    logic [DenW-1:0]        d3_reg;
    logic [NumW-1:0]        abs_r, abs_i;

    always_comb
    begin
        abs_r = nr_reg[NumW-1] ? NumW'(-nr_reg) : NumW'(nr_reg);
        abs_i = ni_reg[NumW-1] ? NumW'(-ni_reg) : NumW'(ni_reg);
        s3_next        = s2_reg;
        s3_next.neg_re = nr_reg[NumW-1];
        s3_next.neg_im = ni_reg[NumW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg        <= s3_next;
            mr_reg        <= {abs_r, 8'd0};
            mi_reg        <= {abs_i, 8'd0};
            d3_reg        <= den_reg;
        end
    end

    assign out_valid = v3_reg;
    assign side      = s3_reg;
    assign mag_re    = mr_reg;
    assign mag_im    = mi_reg;
    assign den       = d3_reg;
endmodule
`default_nettype wire

FILE: rtl/core/cpa_div_stage.sv
// One restoring-division stage: resolves one quotient bit for both parts.
// Depends on cpa_pkg.
`default_nettype none
module cpa_div_stage #(
    parameter int Bit = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire cpa_pkg::side_t                in_side,
    input  wire logic [cpa_pkg::DenW-1:0]      in_den,
    input  wire logic [cpa_pkg::DividW-1:0]    in_rem_re,
    input  wire logic [cpa_pkg::DividW-1:0]    in_rem_im,
    input  wire logic [cpa_pkg::QMagW-1:0]     in_q_re,
    input  wire logic [cpa_pkg::QMagW-1:0]     in_q_im,
    output logic                               out_valid,
    output cpa_pkg::side_t                     out_side,
    output logic [cpa_pkg::DenW-1:0]           out_den,
    output logic [cpa_pkg::DividW-1:0]         out_rem_re,
    output logic [cpa_pkg::DividW-1:0]         out_rem_im,
    output logic [cpa_pkg::QMagW-1:0]          out_q_re,
    output logic [cpa_pkg::QMagW-1:0]          out_q_im
);
    import cpa_pkg::*;

    localparam int ShW = DividW + DenW;

    logic [ShW-1:0]     dsh;
    logic               ge_re, ge_im;
    logic               v_reg;
    side_t              side_reg;
    logic [DenW-1:0]    den_reg;
    logic [DividW-1:0]  rr_reg, ri_reg;
    logic [QMagW-1:0]   qr_reg, qi_reg;

    always_comb
    begin
        dsh   = ShW'(in_den) << Bit;
        ge_re = (in_den != '0) && (ShW'(in_rem_re) >= dsh);
        ge_im = (in_den != '0) && (ShW'(in_rem_im) >= dsh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            den_reg  <= in_den;
            rr_reg   <= ge_re ? DividW'(ShW'(in_rem_re) - dsh) : in_rem_re;
            ri_reg   <= ge_im ? DividW'(ShW'(in_rem_im) - dsh) : in_rem_im;
            qr_reg   <= in_q_re | (QMagW'(ge_re) << Bit);
            qi_reg   <= in_q_im | (QMagW'(ge_im) << Bit);
        end
    end

    assign out_valid  = v_reg;
    assign out_side   = side_reg;
    assign out_den    = den_reg;
    assign out_rem_re = rr_reg;
    assign out_rem_im = ri_reg;
    assign out_q_re   = qr_reg;
    assign out_q_im   = qi_reg;
endmodule
`default_nettype wire

FILE: rtl/core/cpa_back.sv
// Back stage: sign restore, saturation and the zero-divisor override.
// Depends on cpa_pkg.
`default_nettype none
module cpa_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire cpa_pkg::side_t                side,
    input  wire logic [cpa_pkg::QMagW-1:0]     q_re,
    input  wire logic [cpa_pkg::QMagW-1:0]     q_im,
    output logic                               out_valid,
    output logic [cpa_pkg::OutW-1:0]           out_data
);
    import cpa_pkg::*;

    function automatic logic [OpW-1:0] sat_fn(input logic [QMagW-1:0] m, input logic neg);
        logic [OpW-1:0] r;
        if (neg)
            r = (m > QMagW'(32768)) ? 16'h8000 : OpW'(-m);
        else
            r = (m > QMagW'(32767)) ? 16'h7FFF : m[OpW-1:0];
        return r;
    endfunction

    logic              v_reg;
    logic [OutW-1:0]   d_reg;
    logic [OpW-1:0]    qr, qi;

    always_comb
    begin
        qr = side.zero ? '0 : sat_fn(q_re, side.neg_re);
        qi = side.zero ? '0 : sat_fn(q_im, side.neg_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= {2'd0, side.zero, qi, qr, side.prod_im, side.prod_re,
                      side.diff_im, side.diff_re, side.sum_im, side.sum_re};
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;
endmodule
`default_nettype wire

FILE: rtl/core/complex_pair_arithmetic_unit.sv
// Complex pair arithmetic unit: sum, difference, product and quotient of two
// complex Q8.8 operands. Depends on cpa_pkg, cpa_front, cpa_div_stage, cpa_back, assert_macros.svh.
//
// The unit accepts one operand pair per clock and returns one result per pair,
// in order. The pipeline has three front stages (products, numerators and
// |b|^2, sign split), a 41-stage restoring divider resolving one quotient bit
// per stage for both parts at once, and one output stage. The whole pipeline
// advances whenever the output register is empty or being taken, so the unit
// sustains one transaction per cycle under back-to-back traffic; a stall on
// the output side freezes every stage and nothing is lost or repeated.
// A zero divisor sets div_by_zero and forces both quotient parts to zero.
`default_nettype none
module complex_pair_arithmetic_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // a_re, a_im, b_re, b_im (16 bits each, lowest first)
    input  wire logic [cpa_pkg::InW-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // sum_re, sum_im, diff_re, diff_im (17 each), prod_re (32), prod_im (33),
    // quot_re, quot_im (16 each), div_by_zero (1), zero pad to 168 bits
    output logic [cpa_pkg::OutW-1:0]        m_axis_tdata
);
    import cpa_pkg::*;

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic               f_valid;
    side_t              f_side;
    logic [DividW-1:0]  f_mr, f_mi;
    logic [DenW-1:0]    f_den;

    cpa_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .a_re(s_axis_tdata[15:0]), .a_im(s_axis_tdata[31:16]),
        .b_re(s_axis_tdata[47:32]), .b_im(s_axis_tdata[63:48]),
        .out_valid(f_valid), .side(f_side),
        .mag_re(f_mr), .mag_im(f_mi), .den(f_den)
    );

    // Divider chain, most significant quotient bit first.
    logic               c_valid [DivSteps+1];
    side_t              c_side  [DivSteps+1];
    logic [DenW-1:0]    c_den   [DivSteps+1];
    logic [DividW-1:0]  c_rr    [DivSteps+1];
    logic [DividW-1:0]  c_ri    [DivSteps+1];
    logic [QMagW-1:0]   c_qr    [DivSteps+1];
    logic [QMagW-1:0]   c_qi    [DivSteps+1];

    assign c_valid[0] = f_valid;
    assign c_side[0]  = f_side;
    assign c_den[0]   = f_den;
    assign c_rr[0]    = f_mr;
    assign c_ri[0]    = f_mi;
    assign c_qr[0]    = '0;
    assign c_qi[0]    = '0;

    for (genvar g = 0; g < DivSteps; g++)
    begin : g_div
        cpa_div_stage #(.Bit(DivSteps - 1 - g)) u_stage (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(c_valid[g]), .in_side(c_side[g]), .in_den(c_den[g]),
            .in_rem_re(c_rr[g]), .in_rem_im(c_ri[g]),
            .in_q_re(c_qr[g]), .in_q_im(c_qi[g]),
            .out_valid(c_valid[g+1]), .out_side(c_side[g+1]), .out_den(c_den[g+1]),
            .out_rem_re(c_rr[g+1]), .out_rem_im(c_ri[g+1]),
            .out_q_re(c_qr[g+1]), .out_q_im(c_qi[g+1])
        );
    end

    cpa_back u_back (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(c_valid[DivSteps]), .side(c_side[DivSteps]),
        .q_re(c_qr[DivSteps]), .q_im(c_qi[DivSteps]),
        .out_valid(m_axis_tvalid), .out_data(m_axis_tdata)
    );

`include "assert_macros.svh"
    // A stalled result must stay put.
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // A zero divisor always yields a zero quotient.
    `ASSERT_IMPLIES(a_zero_q, clk, rst_n, m_axis_tvalid && m_axis_tdata[165], m_axis_tdata[164:133] == 32'd0)
    // Pad bits stay clear.
    `ASSERT_IMPLIES(a_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[167:166] == 2'd0)
endmodule
`default_nettype wire
